[hw/rtl/fhbs_pkg.sv]
// shared types and constants for the flow hash backend selector
package fhbs_pkg;

   // table sizes; the index arithmetic relies on powers of two
   localparam int LOOKUP_ENTRIES  = 256;
   localparam int SERVICE_ENTRIES = 64;
   localparam int CONN_ENTRIES    = 1024;

   typedef enum logic [1:0] {
      CMD_PACKET  = 2'd0,
      CMD_RING_WR = 2'd1,
      CMD_SVC_WR  = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      V_PASS = 2'd0,
      V_DROP = 2'd1,
      V_FWD  = 2'd2,
      V_DONE = 2'd3
   } verdict_type;

   localparam logic [2:0] CLS_SHORT_ETH = 3'd0;
   localparam logic [2:0] CLS_COMPLETE  = 3'd5;

   localparam logic [0:0] REG_VIP     = 1'b0;
   localparam logic [0:0] REG_TTL_DEC = 1'b1;

   localparam logic [63:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;
   localparam int          MIX_SHIFT = 33;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_MIX_A,
      ST_MUL_A,
      ST_MIX_B,
      ST_MUL_B,
      ST_MIX_C,
      ST_CONN_RD,
      ST_CONN_CHK,
      ST_SVC_CHK,
      ST_RING_RD,
      ST_RING_CHK,
      ST_PROBE_SVC,
      ST_DONE
   } state_type;

   // shared multiplier control
   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] product;
   } mul_rsp_type;

   function automatic logic [31:0] swap32(input logic [31:0] v);
      swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   function automatic logic [15:0] patch_checksum(input logic [15:0] chk,
                                                  input logic [7:0]  old_ttl,
                                                  input logic [7:0]  new_ttl);
      logic [17:0] s;
      logic [16:0] f;
      s = {2'b0, ~chk} + {2'b0, ~{8'h00, old_ttl}} + {10'b0, new_ttl};
      f = {1'b0, s[15:0]} + {15'b0, s[17:16]};
      f = {1'b0, f[15:0]} + {16'b0, f[16]};
      patch_checksum = ~f[15:0];
   endfunction

endpackage

[hw/rtl/fhbs_mul64.sv]
// 64x64 low-half multiplier built from a 32x32 unit
module fhbs_mul64
   import fhbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp
);

   logic [63:0] a_ff, b_ff, acc_ff, acc_in;
   logic [2:0]  step_ff, step_in;
   logic        done_ff, done_in;
   logic [31:0] op_a, op_b;
   logic [63:0] prod_ff;

   // one 32x32 partial product per cycle: al*bl, ah*bl, al*bh
   always_comb begin
      op_a = a_ff[31:0];
      op_b = b_ff[31:0];
      case (step_ff)
         3'd2:    op_a = a_ff[63:32];
         3'd3:    op_b = b_ff[63:32];
         default: ;
      endcase
   end

   always_comb begin
      step_in = step_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (mul_req.start) begin
         step_in = 3'd1;
         acc_in  = '0;
      end else begin
         case (step_ff)
            3'd2: begin
               acc_in  = prod_ff;
               step_in = 3'd3;
            end
            3'd3: begin
               acc_in  = acc_ff + {prod_ff[31:0], 32'b0};
               step_in = 3'd4;
            end
            3'd4: begin
               acc_in  = acc_ff + {prod_ff[31:0], 32'b0};
               step_in = 3'd0;
               done_in = 1'b1;
            end
            3'd1:    step_in = 3'd2;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      if (mul_req.start) begin
         a_ff <= mul_req.a;
         b_ff <= mul_req.b;
      end
      acc_ff  <= acc_in;
      prod_ff <= {32'b0, op_a} * {32'b0, op_b};
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule

[hw/rtl/flow_hash_backend_selector.sv]
// top level: packet classifier, flow hash, connection table and ring probing
// table writes, passes and early drops finish in ST_MIX_A; the result strobe is registered
// hashed packets: two multiplier passes, then a connection table read; a hit whose
// service is active forwards, else ring slots are probed in turn from the hash slot,
// at most LOOKUP_ENTRIES slots; busy falls in the strobe cycle, receiver never stalls
// after reset a clearing pass over all CONN_ENTRIES connection slots runs before busy falls
module flow_hash_backend_selector
   import fhbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [2:0]  req_frame_class,
   input  logic [31:0] req_src_ip,
   input  logic [31:0] req_dst_ip,
   input  logic [15:0] req_sport,
   input  logic [15:0] req_dport,
   input  logic [7:0]  req_ttl,
   input  logic [15:0] req_ip_checksum,
   input  logic [7:0]  req_table_index,
   input  logic [31:0] req_table_value,
   input  logic        req_entry_active,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_verdict,
   output logic [31:0] rsp_target_address,
   output logic [7:0]  rsp_new_ttl,
   output logic [15:0] rsp_new_checksum,
   output logic [31:0] rsp_flow_hash
);

   localparam int LW = $clog2(LOOKUP_ENTRIES);
   localparam int SW = $clog2(SERVICE_ENTRIES);
   localparam int CW = $clog2(CONN_ENTRIES);

   // memories
   logic [SW:0]   ring_mem [LOOKUP_ENTRIES];   // {valid, key}
   logic [SERVICE_ENTRIES-1:0] svc_active_ff;
   logic [31:0]   svc_addr_mem [SERVICE_ENTRIES];
   logic [32+SW:0] conn_mem [CONN_ENTRIES];    // {valid, tag, key}
   logic [LOOKUP_ENTRIES-1:0] ring_valid_ff;

   logic [SW:0]    ring_rd_ff;
   logic [31:0]    svc_rd_ff;
   logic [32+SW:0] conn_rd_ff;

   state_type   state_ff, state_in;
   logic [63:0] x_ff, x_in;
   logic [LW-1:0] slot_ff, slot_in;
   logic [LW:0]   cnt_ff, cnt_in;
   logic [CW:0]   clr_ff, clr_in;
   logic [SW-1:0] key_ff, key_in;
   logic [1:0]  cmd_ff;
   logic [2:0]  cls_ff;
   logic [31:0] sip_ff, dip_ff, tval_ff;
   logic [15:0] sp_ff, dp_ff, chk_ff;
   logic [7:0]  ttl_ff, tidx_ff;
   logic        act_ff;
   logic [31:0] vip_ff;
   logic        ttl_dec_ff;

   logic        out_stb_ff;
   logic [1:0]  out_verdict_ff;
   logic [31:0] out_addr_ff, out_hash_ff;
   logic [7:0]  out_ttl_ff;
   logic [15:0] out_chk_ff;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   // control outputs of the sequencer
   logic        fin, fin_fwd, conn_wr, svc_rd_en;
   logic [1:0]  fin_verdict;
   logic [SW-1:0] svc_rd_addr;

   logic accept;
   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   fhbs_mul64 u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   logic [31:0] h;
   assign h = x_ff[31:0];
   logic [CW-1:0] conn_idx;
   assign conn_idx = h[CW-1:0];

   logic [63:0] tuple_x;
   assign tuple_x = {sip_ff, dip_ff} ^ {32'b0, sp_ff, dp_ff};

   logic        key_ok_ring;
   assign key_ok_ring = ({{(32-SW){1'b0}}, key_in} == tval_ff) &&
                        (tval_ff < 32'(SERVICE_ENTRIES));

   always_comb begin
      state_in    = state_ff;
      x_in        = x_ff;
      slot_in     = slot_ff;
      cnt_in      = cnt_ff;
      clr_in      = clr_ff;
      key_in      = tval_ff[SW-1:0];
      mul_req     = '{start: 1'b0, a: x_ff, b: MIX_MUL_A};
      fin         = 1'b0;
      fin_fwd     = 1'b0;
      fin_verdict = V_PASS;
      conn_wr     = 1'b0;
      svc_rd_en   = 1'b0;
      svc_rd_addr = key_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (CW+1)'(CONN_ENTRIES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: ;
         ST_MIX_A: begin
            // state entered with an item latched: classify first
            if (cmd_ff != CMD_PACKET) begin
               fin = 1'b1;
               fin_verdict = V_DONE;
               state_in = ST_IDLE;
            end else if (cls_ff == CLS_SHORT_ETH) begin
               fin = 1'b1;
               fin_verdict = V_DROP;
               state_in = ST_IDLE;
            end else if (cls_ff != CLS_COMPLETE || dip_ff != swap32(vip_ff)) begin
               fin = 1'b1;
               fin_verdict = V_PASS;
               state_in = ST_IDLE;
            end else if (ttl_ff <= 8'd1) begin
               fin = 1'b1;
               fin_verdict = V_DROP;
               state_in = ST_IDLE;
            end else begin
               x_in = tuple_x ^ (tuple_x >> MIX_SHIFT);
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            mul_req.start = 1'b1;
            state_in = ST_MIX_B;
         end
         ST_MIX_B: if (mul_rsp.done) begin
            x_in = mul_rsp.product ^ (mul_rsp.product >> MIX_SHIFT);
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            mul_req = '{start: 1'b1, a: x_ff, b: MIX_MUL_B};
            state_in = ST_MIX_C;
         end
         ST_MIX_C: if (mul_rsp.done) begin
            x_in = mul_rsp.product ^ (mul_rsp.product >> MIX_SHIFT);
            state_in = ST_CONN_RD;
         end
         ST_CONN_RD: state_in = ST_CONN_CHK;   // conn memory read in flight
         ST_CONN_CHK: begin
            slot_in = h[LW-1:0];
            cnt_in  = '0;
            if (conn_rd_ff[32+SW] && conn_rd_ff[SW+31:SW] == h) begin
               svc_rd_en   = 1'b1;
               svc_rd_addr = conn_rd_ff[SW-1:0];
               key_in      = conn_rd_ff[SW-1:0];
               state_in    = ST_SVC_CHK;
            end else begin
               state_in = ST_RING_RD;
            end
         end
         ST_SVC_CHK: begin
            if (svc_active_ff[key_ff]) begin
               fin = 1'b1;
               fin_fwd = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_RING_RD;
            end
         end
         ST_RING_RD: state_in = ST_RING_CHK;
         ST_RING_CHK: begin
            key_in = ring_rd_ff[SW-1:0];
            if (ring_rd_ff[SW] && ring_valid_ff[slot_ff] &&
                svc_active_ff[ring_rd_ff[SW-1:0]]) begin
               svc_rd_en   = 1'b1;
               svc_rd_addr = ring_rd_ff[SW-1:0];
               state_in    = ST_PROBE_SVC;
            end else if (cnt_ff == (LW+1)'(LOOKUP_ENTRIES - 1)) begin
               fin = 1'b1;
               fin_verdict = V_DROP;
               state_in = ST_IDLE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               slot_in  = (slot_ff == LW'(LOOKUP_ENTRIES - 1)) ? '0 : slot_ff + 1'b1;
               state_in = ST_RING_RD;
            end
         end
         ST_PROBE_SVC: begin
            conn_wr  = 1'b1;
            fin      = 1'b1;
            fin_fwd  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_IDLE && accept) state_in = ST_MIX_A;
      if (state_ff == ST_CLEAR) key_in = key_ff;
   end

   // memories and payload latches
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_command;
         cls_ff  <= req_frame_class;
         sip_ff  <= req_src_ip;
         dip_ff  <= req_dst_ip;
         sp_ff   <= req_sport;
         dp_ff   <= req_dport;
         ttl_ff  <= req_ttl;
         chk_ff  <= req_ip_checksum;
         tidx_ff <= req_table_index;
         tval_ff <= req_table_value;
         act_ff  <= req_entry_active;
      end
      x_ff    <= x_in;
      slot_ff <= slot_in;
      cnt_ff  <= cnt_in;
      key_ff  <= key_in;
      // table writes happen in ST_MIX_A, the state entered on acceptance
      if (state_ff == ST_MIX_A && cmd_ff == CMD_RING_WR &&
          {24'b0, tidx_ff} < 32'(LOOKUP_ENTRIES)) begin
         ring_mem[tidx_ff[LW-1:0]] <= {act_ff && key_ok_ring,
                                       tval_ff[SW-1:0]};
      end
      if (state_ff == ST_MIX_A && cmd_ff == CMD_SVC_WR &&
          {24'b0, tidx_ff} < 32'(SERVICE_ENTRIES)) begin
         svc_addr_mem[tidx_ff[SW-1:0]] <= tval_ff;
      end
      if (state_ff == ST_CLEAR) begin
         conn_mem[clr_ff[CW-1:0]] <= '0;
      end else if (conn_wr) begin
         conn_mem[conn_idx] <= {1'b1, h, key_ff};
      end
      ring_rd_ff <= ring_mem[slot_ff];
      conn_rd_ff <= conn_mem[conn_idx];
      if (svc_rd_en) svc_rd_ff <= svc_addr_mem[svc_rd_addr];
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         vip_ff        <= '0;
         ttl_dec_ff    <= 1'b1;
         ring_valid_ff <= '0;
         svc_active_ff <= '0;
         out_stb_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         out_stb_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_VIP:     vip_ff     <= csr_data;
               REG_TTL_DEC: ttl_dec_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (state_ff == ST_MIX_A && cmd_ff == CMD_RING_WR &&
             {24'b0, tidx_ff} < 32'(LOOKUP_ENTRIES)) begin
            ring_valid_ff[tidx_ff[LW-1:0]] <= act_ff && key_ok_ring;
         end
         if (state_ff == ST_MIX_A && cmd_ff == CMD_SVC_WR &&
             {24'b0, tidx_ff} < 32'(SERVICE_ENTRIES)) begin
            svc_active_ff[tidx_ff[SW-1:0]] <= act_ff;
         end
         if (fin) out_stb_ff <= 1'b1;
      end
   end

   // result register; forwards are marked pending in fwd_pend_ff and finish from the service address
   logic        fwd_pend_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_pend_ff <= 1'b0;
      end else begin
         fwd_pend_ff <= fin && fin_fwd;
      end
      if (fin && !fin_fwd) begin
         out_verdict_ff <= fin_verdict;
         out_addr_ff    <= '0;
         out_ttl_ff     <= '0;
         out_chk_ff     <= '0;
         out_hash_ff    <= (state_ff == ST_RING_CHK) ? h : 32'b0;
      end
      if (fin && fin_fwd) out_hash_ff <= h;
   end

   // forward results resolve after the service address read
   logic        fwd_zero;
   assign fwd_zero = (svc_rd_ff == 32'b0);

   assign rsp_strobe         = out_stb_ff;
   assign rsp_verdict        = fwd_pend_ff ? (fwd_zero ? V_DROP : V_FWD) : out_verdict_ff;
   assign rsp_target_address = fwd_pend_ff ? (fwd_zero ? 32'b0 : svc_rd_ff) : out_addr_ff;
   assign rsp_new_ttl        = fwd_pend_ff ?
                               (fwd_zero ? 8'b0 : (ttl_dec_ff ? ttl_ff - 8'd1 : ttl_ff)) :
                               out_ttl_ff;
   assign rsp_new_checksum   = fwd_pend_ff ?
                               (fwd_zero ? 16'b0 :
                                (ttl_dec_ff ? patch_checksum(chk_ff, ttl_ff, ttl_ff - 8'd1)
                                            : chk_ff)) :
                               out_chk_ff;
   assign rsp_flow_hash      = out_hash_ff;

endmodule

[verif/flow_hash_backend_selector_test.sv]
// self-checking testbench for the flow hash backend selector
module flow_hash_backend_selector_test
   import fhbs_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_SLOTS   = LOOKUP_ENTRIES;
   localparam int SERVICES     = SERVICE_ENTRIES;
   localparam int CONN_SLOTS   = CONN_ENTRIES;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int RANDOM_ITEMS = 400;

   typedef struct {
      cmd_type     command;
      logic [2:0]  frame_class;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  ttl;
      logic [15:0] ip_checksum;
      logic [7:0]  table_index;
      logic [31:0] table_value;
      logic        entry_active;
   } packet_type;

   typedef struct {
      verdict_type verdict;
      logic [31:0] target_address;
      logic [7:0]  new_ttl;
      logic [15:0] new_checksum;
      logic [31:0] flow_hash;
   } result_type;

   typedef struct {
      packet_type  item;
      logic        typed_in;
      result_type  known;
   } stimulus_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_command = '0;
   logic [2:0]  req_frame_class = '0;
   logic [31:0] req_src_ip = '0;
   logic [31:0] req_dst_ip = '0;
   logic [15:0] req_sport = '0;
   logic [15:0] req_dport = '0;
   logic [7:0]  req_ttl = '0;
   logic [15:0] req_ip_checksum = '0;
   logic [7:0]  req_table_index = '0;
   logic [31:0] req_table_value = '0;
   logic        req_entry_active = 1'b0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   logic        rsp_strobe;
   logic [1:0]  rsp_verdict;
   logic [31:0] rsp_target_address;
   logic [7:0]  rsp_new_ttl;
   logic [15:0] rsp_new_checksum;
   logic [31:0] rsp_flow_hash;

   flow_hash_backend_selector uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state
   logic [31:0] vip_reg;
   logic        ttl_dec_reg;
   logic        ring_used [RING_SLOTS];
   logic [31:0] ring_service [RING_SLOTS];
   logic        svc_on [SERVICES];
   logic [31:0] svc_backend [SERVICES];
   logic        conn_used [CONN_SLOTS];
   logic [31:0] conn_hash [CONN_SLOTS];
   logic [31:0] conn_service [CONN_SLOTS];

   result_type       pending_verdicts[$];
   stimulus_row_type directed_rows[$];
   int          error_count = 0;
   int          verdicts_seen = 0;
   int          forwards_seen = 0;
   int          drops_seen = 0;
   int          items_sent = 0;
   int          cycle_count = 0;
   logic        burst_mode = 1'b0;

   function automatic logic [31:0] reverse_octets(input logic [31:0] v);
      logic [31:0] r;
      for (int i = 0; i < 4; i++) r[8*i +: 8] = v[8*(3-i) +: 8];
      return r;
   endfunction

   function automatic logic [31:0] tuple_hash(input logic [31:0] sip, input logic [31:0] dip,
                                              input logic [15:0] sp, input logic [15:0] dp);
      logic [63:0] x;
      x = {sip, dip};
      x ^= {32'd0, sp, dp};
      x ^= x >> MIX_SHIFT;
      x = x * MIX_MUL_A;
      x ^= x >> MIX_SHIFT;
      x = x * MIX_MUL_B;
      x ^= x >> MIX_SHIFT;
      return x[31:0];
   endfunction

   function automatic logic [15:0] ttl_checksum(input logic [15:0] chk, input logic [7:0] old_ttl,
                                                input logic [7:0] new_ttl);
      logic [31:0] s;
      s = {16'd0, ~chk} + {16'd0, 8'hFF, ~old_ttl} + {24'd0, new_ttl};
      s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
      s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
      return ~s[15:0];
   endfunction

   // true when an active service is found, with its backend address
   function automatic logic pick_backend(input logic [31:0] h, output logic [31:0] addr);
      int          ci;
      int          first;
      int          slot;
      logic [31:0] key;
      ci = int'(h % CONN_SLOTS);
      addr = '0;
      if (conn_used[ci] && conn_hash[ci] == h) begin
         key = conn_service[ci];
         if (key < SERVICES && svc_on[key]) begin
            addr = svc_backend[key];
            return 1'b1;
         end
      end
      first = int'(h % RING_SLOTS);
      for (int i = 0; i < RING_SLOTS; i++) begin
         slot = (first + i) % RING_SLOTS;
         key = ring_service[slot];
         if (ring_used[slot] && key < SERVICES && svc_on[key]) begin
            conn_used[ci] = 1'b1;
            conn_hash[ci] = h;
            conn_service[ci] = key;
            addr = svc_backend[key];
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic result_type predict_verdict(input packet_type it);
      result_type  r;
      logic        found;
      logic [31:0] addr;
      r = '{V_PASS, '0, '0, '0, '0};
      case (it.command)
         CMD_RING_WR: begin
            if (it.table_index < RING_SLOTS) begin
               found = it.entry_active && it.table_value < SERVICES;
               ring_used[it.table_index] = found;
               ring_service[it.table_index] = found ? it.table_value : '0;
            end
            r.verdict = V_DONE;
         end
         CMD_SVC_WR: begin
            if (it.table_index < SERVICES) begin
               svc_on[it.table_index] = it.entry_active;
               svc_backend[it.table_index] = it.table_value;
            end
            r.verdict = V_DONE;
         end
         CMD_NOP: r.verdict = V_DONE;
         default: begin
            if (it.frame_class == CLS_SHORT_ETH) r.verdict = V_DROP;
            else if (it.frame_class != CLS_COMPLETE) r.verdict = V_PASS;
            else if (it.dst_ip != reverse_octets(vip_reg)) r.verdict = V_PASS;
            else if (it.ttl <= 8'd1) r.verdict = V_DROP;
            else begin
               r.flow_hash = tuple_hash(it.src_ip, it.dst_ip, it.sport, it.dport);
               found = pick_backend(r.flow_hash, addr);
               if (!found || addr == '0) r.verdict = V_DROP;
               else begin
                  r.verdict = V_FWD;
                  r.target_address = addr;
                  r.new_ttl = ttl_dec_reg ? it.ttl - 8'd1 : it.ttl;
                  r.new_checksum = ttl_dec_reg ?
                                   ttl_checksum(it.ip_checksum, it.ttl, it.ttl - 8'd1) :
                                   it.ip_checksum;
               end
            end
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_strobe) begin
         verdicts_seen++;
         if (pending_verdicts.size() == 0) begin
            report_mismatch("strobe with no transaction outstanding", 32'(rsp_verdict), 32'd0);
         end else begin
            want = pending_verdicts.pop_front();
            if (want.verdict == V_FWD) forwards_seen++;
            if (want.verdict == V_DROP) drops_seen++;
            if (rsp_verdict != want.verdict)
               report_mismatch("verdict", 32'(rsp_verdict), 32'(want.verdict));
            if (rsp_target_address != want.target_address)
               report_mismatch("target_address", rsp_target_address, want.target_address);
            if (rsp_new_ttl != want.new_ttl)
               report_mismatch("new_ttl", 32'(rsp_new_ttl), 32'(want.new_ttl));
            if (rsp_new_checksum != want.new_checksum)
               report_mismatch("new_checksum", 32'(rsp_new_checksum), 32'(want.new_checksum));
            if (rsp_flow_hash != want.flow_hash)
               report_mismatch("flow_hash", rsp_flow_hash, want.flow_hash);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** flow_hash_backend_selector: FAILED **");
         $finish;
      end
   end

   task automatic send_item(input packet_type it, input logic typed_in, input result_type known);
      int          gap;
      result_type  got;
      gap = burst_mode ? 0 : $urandom_range(0, 18);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      req_command      <= it.command;
      req_frame_class  <= it.frame_class;
      req_src_ip       <= it.src_ip;
      req_dst_ip       <= it.dst_ip;
      req_sport        <= it.sport;
      req_dport        <= it.dport;
      req_ttl          <= it.ttl;
      req_ip_checksum  <= it.ip_checksum;
      req_table_index  <= it.table_index;
      req_table_value  <= it.table_value;
      req_entry_active <= it.entry_active;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
      got = predict_verdict(it);
      pending_verdicts.push_back(typed_in ? known : got);
      items_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [0:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_VIP) vip_reg = value;
      else ttl_dec_reg = value[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic packet_type blank_item(input cmd_type c);
      packet_type it;
      it = '{c, CLS_COMPLETE, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0};
      return it;
   endfunction

   function automatic void add_row(input packet_type it, input logic typed_in,
                                   input verdict_type v);
      stimulus_row_type r;
      r.item = it;
      r.typed_in = typed_in;
      r.known = '{v, '0, '0, '0, '0};
      directed_rows.push_back(r);
   endfunction

   function automatic packet_type table_write(input cmd_type c, input logic [7:0] idx,
                                              input logic [31:0] value, input logic act);
      packet_type it;
      it = blank_item(c);
      it.table_index = idx;
      it.table_value = value;
      it.entry_active = act;
      return it;
   endfunction

   function automatic packet_type vip_packet(input logic [31:0] sip, input logic [15:0] sp,
                                             input logic [7:0] ttl, input logic [15:0] chk);
      packet_type it;
      it = blank_item(CMD_PACKET);
      it.src_ip = sip;
      it.dst_ip = reverse_octets(vip_reg);
      it.sport = sp;
      it.dport = 16'h5000;
      it.ttl = ttl;
      it.ip_checksum = chk;
      return it;
   endfunction

   function automatic void build_directed();
      packet_type it;
      for (int c = 0; c < 8; c++) begin
         it = vip_packet(32'h0100000A, 16'h1234, 8'd64, 16'hBEEF);
         it.frame_class = c[2:0];
         // only the complete class reaches the address check
         if (c == 0) add_row(it, 1'b1, V_DROP);
         else add_row(it, c != 5, V_PASS);
      end
      it = blank_item(CMD_NOP);
      add_row(it, 1'b1, V_DONE);
      add_row(vip_packet(32'hFFFFFFFF, 16'hFFFF, 8'd1, 16'h0000), 1'b1, V_DROP);
      add_row(vip_packet(32'h00000000, 16'h0000, 8'd0, 16'hFFFF), 1'b1, V_DROP);
      // no service yet: dropped with a hash
      add_row(vip_packet(32'h0200000A, 16'h8000, 8'd64, 16'h1234), 1'b0, V_DROP);
      add_row(table_write(CMD_SVC_WR, 8'd63, 32'hFFFFFFFF, 1'b1), 1'b1, V_DONE);
      add_row(table_write(CMD_SVC_WR, 8'd64, 32'h12345678, 1'b1), 1'b1, V_DONE);
      add_row(table_write(CMD_SVC_WR, 8'd255, 32'h87654321, 1'b1), 1'b1, V_DONE);
      add_row(table_write(CMD_SVC_WR, 8'd3, 32'h00000000, 1'b1), 1'b1, V_DONE);
      add_row(table_write(CMD_RING_WR, 8'd0, 32'd63, 1'b1), 1'b1, V_DONE);
      add_row(table_write(CMD_RING_WR, 8'd255, 32'd99, 1'b1), 1'b1, V_DONE);
      add_row(table_write(CMD_RING_WR, 8'd5, 32'd3, 1'b0), 1'b1, V_DONE);
      add_row(table_write(CMD_RING_WR, 8'd128, 32'd3, 1'b1), 1'b1, V_DONE);
      add_row(vip_packet(32'h0300000A, 16'h0050, 8'd255, 16'hFFFF), 1'b0, V_FWD);
      add_row(vip_packet(32'h0400000A, 16'h0051, 8'd2, 16'h0000), 1'b0, V_FWD);
      add_row(vip_packet(32'h0300000A, 16'h0050, 8'd200, 16'h8001), 1'b0, V_FWD);
      // tracked service goes inactive: probing again
      add_row(table_write(CMD_SVC_WR, 8'd63, 32'hC0A80001, 1'b0), 1'b1, V_DONE);
      add_row(vip_packet(32'h0300000A, 16'h0050, 8'd100, 16'h4242), 1'b0, V_DROP);
      add_row(table_write(CMD_SVC_WR, 8'd0, 32'hC0A80002, 1'b1), 1'b1, V_DONE);
      add_row(table_write(CMD_RING_WR, 8'd77, 32'd0, 1'b1), 1'b1, V_DONE);
   endfunction

   packet_type flow_pool [8];

   function automatic packet_type random_item();
      packet_type it;
      int         pick;
      int         f;
      pick = $urandom_range(0, 99);
      it.command = CMD_PACKET;
      it.frame_class = CLS_COMPLETE;
      it.src_ip = $urandom();
      it.dst_ip = reverse_octets(vip_reg);
      it.sport = 16'($urandom());
      it.dport = 16'($urandom());
      it.ttl = 8'($urandom());
      it.ip_checksum = 16'($urandom());
      it.table_index = 8'($urandom());
      it.table_value = $urandom();
      it.entry_active = $urandom_range(0, 3) != 0;
      if (pick < 12) begin
         it.command = CMD_RING_WR;
         if ($urandom_range(0, 9) != 0) it.table_value = $urandom_range(0, SERVICES - 1);
      end else if (pick < 20) begin
         it.command = CMD_SVC_WR;
         if ($urandom_range(0, 5) != 0) it.table_index = 8'($urandom_range(0, SERVICES - 1));
         if ($urandom_range(0, 9) == 0) it.table_value = '0;
      end else if (pick < 22) begin
         it.command = CMD_NOP;
      end else begin
         if ($urandom_range(0, 1) == 0) begin
            // revisit a known flow so the connection table gets hits
            f = $urandom_range(0, 7);
            it.src_ip = flow_pool[f].src_ip;
            it.sport = flow_pool[f].sport;
            it.dport = flow_pool[f].dport;
         end
         if ($urandom_range(0, 6) == 0) it.frame_class = 3'($urandom_range(0, 7));
         if ($urandom_range(0, 6) == 0) it.dst_ip = $urandom();
         case ($urandom_range(0, 9))
            0: it.ttl = 8'($urandom_range(0, 1));
            1: it.ttl = 8'hFF;
            default: ;
         endcase
      end
      return it;
   endfunction

   initial begin
      result_type  none;
      logic [31:0] phase_vip [4];
      none = '{V_PASS, '0, '0, '0, '0};
      vip_reg = '0;
      ttl_dec_reg = 1'b1;
      for (int i = 0; i < RING_SLOTS; i++) begin
         ring_used[i] = 1'b0;
         ring_service[i] = '0;
      end
      for (int i = 0; i < SERVICES; i++) begin
         svc_on[i] = 1'b0;
         svc_backend[i] = '0;
      end
      for (int i = 0; i < CONN_SLOTS; i++) begin
         conn_used[i] = 1'b0;
         conn_hash[i] = '0;
         conn_service[i] = '0;
      end
      for (int i = 0; i < 8; i++) begin
         flow_pool[i].src_ip = $urandom();
         flow_pool[i].sport = 16'($urandom());
         flow_pool[i].dport = 16'($urandom());
      end
      phase_vip[0] = 32'hFFFFFFFF;
      phase_vip[1] = 32'h00000000;
      phase_vip[2] = $urandom();
      phase_vip[3] = $urandom();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_register(REG_VIP, 32'h0A000001);
      build_directed();
      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed_in, directed_rows[i].known);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         write_register(REG_VIP, phase_vip[p]);
         write_register(REG_TTL_DEC, p[0] ? 32'd1 : 32'd0);
         for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
            if (n % 20 == 0) burst_mode = $urandom_range(0, 3) == 0;
            send_item(random_item(), 1'b0, none);
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      $display("covered %0d transactions: %0d forwards, %0d drops, %0d verdicts checked",
               items_sent, forwards_seen, drops_seen, verdicts_seen);
      $display("four register settings including all-ones and zero virtual address");
      if (error_count == 0)
         $display("** flow_hash_backend_selector: PASSED **");
      else
         $display("** flow_hash_backend_selector: FAILED **");
      $finish;
   end

endmodule
